@@ src/cdsp_pkg.sv @@
// Shared types and constants for the strided, padded 2-D convolution block.
package cdsp_pkg;

  localparam int MAX_CHANNELS    = 8;
  localparam int MAX_FILTERS     = 16;
  localparam int MAX_IMAGE_SIDE  = 64;
  localparam int MAX_KERNEL_SIDE = 5;

  localparam int IMG_DEPTH = MAX_CHANNELS * MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
  localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
  localparam int IMG_AW = $clog2(IMG_DEPTH);
  localparam int WGT_AW = $clog2(WGT_DEPTH);

  typedef enum logic [1:0] {
    CMD_PIXEL   = 2'd0,
    CMD_WEIGHT  = 2'd1,
    CMD_BIAS    = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_STRIDE  = 3'd0,
    REG_PADDING = 3'd1,
    REG_IMG_H   = 3'd2,
    REG_IMG_W   = 3'd3,
    REG_KER_H   = 3'd4,
    REG_KER_W   = 3'd5,
    REG_CHAN    = 3'd6
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_BIAS,
    ST_DONE
  } state_t;

  // Clamped configuration, held as used by the sequencer.
  typedef struct packed {
    logic [2:0] stride;
    logic [2:0] pad;
    logic [6:0] img_h;
    logic [6:0] img_w;
    logic [2:0] ker_h;
    logic [2:0] ker_w;
    logic [3:0] chans;
  } cfg_t;

  // Memory write request from the sequencer.
  typedef struct packed {
    logic              img_we;
    logic [IMG_AW-1:0] img_addr;
    logic              wgt_we;
    logic [WGT_AW-1:0] wgt_addr;
    logic              bias_we;
    logic [3:0]        bias_addr;
    logic [15:0]       wdata;
  } memwr_t;

  // Memory read request from the sequencer.
  typedef struct packed {
    logic              img_en;
    logic [IMG_AW-1:0] img_addr;
    logic [WGT_AW-1:0] wgt_addr;
    logic [3:0]        bias_addr;
  } memrd_t;

endpackage

@@ src/cdsp_mem.sv @@
// Image, weight and bias stores with registered reads.
module cdsp_mem import cdsp_pkg::*; (
  input  logic        clk,
  input  memwr_t      wr,
  input  memrd_t      rd,
  output logic [15:0] img_q,  // zero when the tap falls in the padding
  output logic [15:0] wgt_q,
  output logic [15:0] bias_q
);

  logic [15:0] img_mem  [IMG_DEPTH];
  logic [15:0] wgt_mem  [WGT_DEPTH];
  logic [15:0] bias_mem [MAX_FILTERS];
  logic [15:0] img_raw;
  logic        img_vld;

  always_ff @(posedge clk) begin
    if (wr.img_we) img_mem[wr.img_addr] <= wr.wdata;
    img_raw <= img_mem[rd.img_addr];
    img_vld <= rd.img_en;
  end

  always_ff @(posedge clk) begin
    if (wr.wgt_we) wgt_mem[wr.wgt_addr] <= wr.wdata;
    wgt_q <= wgt_mem[rd.wgt_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.bias_we) bias_mem[wr.bias_addr] <= wr.wdata;
    bias_q <= bias_mem[rd.bias_addr];
  end

  assign img_q = img_vld ? img_raw : 16'd0;

endmodule

@@ src/cdsp_mac.sv @@
// Multiply-accumulate datapath: one product a cycle, bias add and saturation.
module cdsp_mac import cdsp_pkg::*; (
  input  logic               clk,
  input  logic               clear,
  input  logic               mul_en,
  input  logic               acc_en,
  input  logic               bias_en,
  input  logic signed [15:0] px,
  input  logic signed [15:0] wt,
  input  logic signed [15:0] bias,
  output logic signed [39:0] result
);

  logic signed [31:0] prod;
  logic signed [47:0] acc;
  logic signed [47:0] bias_ext;

  assign bias_ext = {{24{bias[15]}}, bias, 8'd0};

  always_ff @(posedge clk) begin
    if (mul_en) prod <= px * wt;
    if (clear) acc <= '0;
    else if (acc_en) acc <= acc + {{16{prod[31]}}, prod};
    else if (bias_en) acc <= acc + bias_ext;
  end

  // The sum stays well inside 40 bits at the default sizes; saturate anyway.
  always_comb begin
    if (acc > 48'sh007F_FFFF_FFFF) result = 40'sh7F_FFFF_FFFF;
    else if (acc < -48'sh0080_0000_0000) result = -40'sh80_0000_0000;
    else result = acc[39:0];
  end

endmodule

@@ src/conv2d_forward_stride_pad.sv @@
// Top level of the strided, zero-padded multi-channel 2-D convolution block.
// Load items (pixel, weight, bias) give no result.
// A compute item walks channels_used * kernel_height * kernel_width taps, one
// image and one weight read per cycle from the stores, then adds the bias.
// The result sits in an output register, and the next item is taken as soon
// as it is loaded. Stores have no reset: reading an entry never written
// gives an undefined value.
module conv2d_forward_stride_pad import cdsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: value[15:0], filter_index[19:16], channel_index[22:20],
  //        row_index[28:23], col_index[34:29], zero [39:35]
  input  logic [39:0] s_tdata,
  // tuser: command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: conv_out[39:0], out_filter[43:40], out_row[49:44], out_col[55:50]
  output logic [55:0] m_tdata,
  // tuser: bad_position[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // raw register copies
  logic [2:0] stride, padding, ker_h, ker_w;
  logic [6:0] img_h, img_w;
  logic [3:0] chans;
  cfg_t       cfg;

  state_t state, state_next;

  // latched item
  cmd_t        cmd;
  logic [15:0] val;
  logic [3:0]  fi;
  logic [2:0]  ch;
  logic [5:0]  ri, ci;

  // tap counters
  logic [2:0] k, i, j;
  logic       bad;
  logic [8:0] hy, wy;
  logic [7:0] pr_base, pc_base;
  logic signed [9:0] pr, pc;
  logic       last_tap;
  logic [1:0] drain;

  memwr_t wr;
  memrd_t rd;
  logic [15:0] img_q, wgt_q, bias_q;
  logic        rd_q, rd_qq;
  logic signed [39:0] result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= 3'd1; padding <= 3'd0; img_h <= 7'd64; img_w <= 7'd64;
      ker_h <= 3'd3; ker_w <= 3'd3; chans <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STRIDE:  stride  <= cfg_data[2:0];
        REG_PADDING: padding <= cfg_data[2:0];
        REG_IMG_H:   img_h   <= cfg_data[6:0];
        REG_IMG_W:   img_w   <= cfg_data[6:0];
        REG_KER_H:   ker_h   <= cfg_data[2:0];
        REG_KER_W:   ker_w   <= cfg_data[2:0];
        REG_CHAN:    chans   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // saturate each register into its legal range
  always_comb begin
    cfg.stride = (stride == 3'd0) ? 3'd1 : (stride > 3'd4) ? 3'd4 : stride;
    cfg.pad    = (padding > 3'd4) ? 3'd4 : padding;
    cfg.img_h  = (img_h == 7'd0) ? 7'd1 : (img_h > 7'(MAX_IMAGE_SIDE)) ?
                 7'(MAX_IMAGE_SIDE) : img_h;
    cfg.img_w  = (img_w == 7'd0) ? 7'd1 : (img_w > 7'(MAX_IMAGE_SIDE)) ?
                 7'(MAX_IMAGE_SIDE) : img_w;
    cfg.ker_h  = (ker_h == 3'd0) ? 3'd1 : (ker_h > 3'(MAX_KERNEL_SIDE)) ?
                 3'(MAX_KERNEL_SIDE) : ker_h;
    cfg.ker_w  = (ker_w == 3'd0) ? 3'd1 : (ker_w > 3'(MAX_KERNEL_SIDE)) ?
                 3'(MAX_KERNEL_SIDE) : ker_w;
    cfg.chans  = (chans == 4'd0) ? 4'd1 : (chans > 4'(MAX_CHANNELS)) ?
                 4'(MAX_CHANNELS) : chans;
  end

  // Output size per axis: (img + 2p - ker) / s + 1. Small divide by 1..4:
  // shift for 1,2,4; for 3 a reciprocal multiply with 8-bit input.
  function automatic logic [8:0] osize(input logic [6:0] img, input logic [2:0] p,
                                       input logic [2:0] ker, input logic [2:0] s);
    logic [7:0]  padded;
    logic [7:0]  d;
    logic [7:0]  q;
    logic [16:0] m;
    padded = 8'(img) + {4'd0, p, 1'b0};
    d = padded - 8'(ker);
    m = 17'(d) * 17'd171;
    unique case (s)
      3'd1: q = d;
      3'd2: q = d >> 1;
      3'd3: q = m[16:9];
      default: q = d >> 2;
    endcase
    osize = (padded < 8'(ker)) ? 9'd0 : 9'(q) + 9'd1;
  endfunction

  always_ff @(posedge clk) begin
    hy <= osize(cfg.img_h, cfg.pad, cfg.ker_h, cfg.stride);
    wy <= osize(cfg.img_w, cfg.pad, cfg.ker_w, cfg.stride);
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_t'(s_tuser);
      val <= s_tdata[15:0];
      fi  <= s_tdata[19:16];
      ch  <= s_tdata[22:20];
      ri  <= s_tdata[28:23];
      ci  <= s_tdata[34:29];
    end
  end

  assign last_tap = (j == cfg.ker_w - 3'd1) && (i == cfg.ker_h - 3'd1) &&
                    ({1'b0, k} == cfg.chans - 4'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (cmd != CMD_COMPUTE) state_next = ST_IDLE;
        else if (bad) state_next = ST_DONE;
        else state_next = ST_RUN;
      end
      ST_RUN:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (drain == 2'd2) state_next = ST_BIAS;
      ST_BIAS:  state_next = ST_DONE;
      ST_DONE:  if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign bad = ({3'd0, ri} >= hy) || ({3'd0, ci} >= wy);

  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      k <= '0; i <= '0; j <= '0; drain <= '0;
      pr_base <= 8'(ri) * 8'(cfg.stride);
      pc_base <= 8'(ci) * 8'(cfg.stride);
    end else if (state == ST_RUN) begin
      if (j == cfg.ker_w - 3'd1) begin
        j <= '0;
        if (i == cfg.ker_h - 3'd1) begin
          i <= '0;
          k <= k + 3'd1;
        end else i <= i + 3'd1;
      end else j <= j + 3'd1;
    end else if (state == ST_DRAIN) drain <= drain + 2'd1;
  end

  assign pr = $signed({2'b0, pr_base}) + $signed({7'd0, i}) - $signed({7'd0, cfg.pad});
  assign pc = $signed({2'b0, pc_base}) + $signed({7'd0, j}) - $signed({7'd0, cfg.pad});

  always_comb begin
    wr = '0;
    wr.wdata = val;
    if (state == ST_CHECK) begin
      unique case (cmd)
        CMD_PIXEL: begin
          wr.img_we   = 1'b1;
          wr.img_addr = {ch, ri, ci};
        end
        CMD_WEIGHT: begin
          wr.wgt_we   = (ri < 6'(MAX_KERNEL_SIDE)) && (ci < 6'(MAX_KERNEL_SIDE));
          wr.wgt_addr = WGT_AW'((((12'(fi) * 12'(MAX_CHANNELS) + 12'(ch)) *
                        12'(MAX_KERNEL_SIDE) + 12'(ri)) * 12'(MAX_KERNEL_SIDE)) + 12'(ci));
        end
        CMD_BIAS: begin
          wr.bias_we   = 1'b1;
          wr.bias_addr = fi;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd.img_en    = (state == ST_RUN) && (pr >= 0) && (pc >= 0) &&
                   (pr < $signed({3'd0, cfg.img_h})) && (pc < $signed({3'd0, cfg.img_w}));
    rd.img_addr  = {k, pr[5:0], pc[5:0]};
    rd.wgt_addr  = WGT_AW'((((12'(fi) * 12'(MAX_CHANNELS) + 12'(k)) *
                   12'(MAX_KERNEL_SIDE) + 12'(i)) * 12'(MAX_KERNEL_SIDE)) + 12'(j));
    rd.bias_addr = fi;
  end

  cdsp_mem u_mem (
    .clk(clk), .wr(wr), .rd(rd), .img_q(img_q), .wgt_q(wgt_q), .bias_q(bias_q)
  );

  // read valid -> product valid -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_q <= 1'b0; rd_qq <= 1'b0;
    end else begin
      rd_q  <= (state == ST_RUN);
      rd_qq <= rd_q;
    end
  end

  cdsp_mac u_mac (
    .clk(clk), .clear(state == ST_CHECK), .mul_en(rd_q), .acc_en(rd_qq),
    .bias_en(state == ST_BIAS), .px(img_q), .wt(wgt_q), .bias(bias_q),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {ci, ri, fi, bad ? 40'd0 : result};
      m_tuser <= bad;
    end
  end

endmodule

@@ src/cdsp_checker.sv @@
// Port-level assertions for the convolution block, bound to the top level.
module cdsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[39:0] == 40'd0)
    else $error("bad position with nonzero sum");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken back to back");

  a_no_out_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind conv2d_forward_stride_pad cdsp_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

@@ tb/tb_conv2d_forward_stride_pad.sv @@
// Self-checking testbench for the strided, zero-padded 2-D convolution block.
`timescale 1ns / 1ps

module tb_conv2d_forward_stride_pad;
  import cdsp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 300;   // longer than one full compute

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] val;
    logic [3:0]  filt;
    logic [2:0]  chan;
    logic [5:0]  row;
    logic [5:0]  col;
  } conv_item_t;

  typedef struct packed {
    logic [39:0] acc;
    logic [3:0]  filt;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        bad;
  } conv_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  conv2d_forward_stride_pad dut (.*);

  // Items waiting for the driver, results waiting for the monitor.
  conv_item_t  pending[$];
  conv_res_t   expected_results[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 22;
  int          recv_idle_pct = 81;

  // Predictor state: raw register values and shadow stores.
  int unsigned         regs[7];
  logic signed [15:0]  img_mem[IMG_DEPTH];
  logic signed [15:0]  wgt_mem[WGT_DEPTH];
  logic signed [15:0]  bias_mem[MAX_FILTERS];
  // Which entries the stimulus has already loaded.
  bit                  img_set[IMG_DEPTH];
  bit                  wgt_set[WGT_DEPTH];
  bit                  bias_set[MAX_FILTERS];

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Output size along one axis; zero when the kernel exceeds the padded image.
  function automatic int span(int img, int pad, int ker, int s);
    int padded;
    padded = img + 2 * pad;
    return (padded < ker) ? 0 : (padded - ker) / s + 1;
  endfunction

  // Effective (clamped) settings: stride, pad, h, w, kh, kw, channels.
  function automatic void eff_cfg(output int e[7]);
    e[0] = clip(regs[REG_STRIDE], 1, 4);
    e[1] = clip(regs[REG_PADDING], 0, 4);
    e[2] = clip(regs[REG_IMG_H], 1, MAX_IMAGE_SIDE);
    e[3] = clip(regs[REG_IMG_W], 1, MAX_IMAGE_SIDE);
    e[4] = clip(regs[REG_KER_H], 1, MAX_KERNEL_SIDE);
    e[5] = clip(regs[REG_KER_W], 1, MAX_KERNEL_SIDE);
    e[6] = clip(regs[REG_CHAN], 1, MAX_CHANNELS);
  endfunction

  function automatic int img_addr(int ch, int r, int c);
    return (ch * MAX_IMAGE_SIDE + r) * MAX_IMAGE_SIDE + c;
  endfunction

  function automatic int wgt_addr(int f, int ch, int r, int c);
    return ((f * MAX_CHANNELS + ch) * MAX_KERNEL_SIDE + r) * MAX_KERNEL_SIDE + c;
  endfunction

  // Apply one accepted item to the shadow stores; queue a result for computes.
  function automatic void conv_predict(conv_item_t it);
    int e[7];
    int hy, wy, pr, pc;
    longint sum;
    logic signed [15:0] px;
    conv_res_t res;
    case (it.cmd)
      CMD_PIXEL: img_mem[img_addr(it.chan, it.row, it.col)] = it.val;
      CMD_WEIGHT: begin
        if (it.row < MAX_KERNEL_SIDE && it.col < MAX_KERNEL_SIDE)
          wgt_mem[wgt_addr(it.filt, it.chan, it.row, it.col)] = it.val;
      end
      CMD_BIAS: bias_mem[it.filt] = it.val;
      default: begin
        eff_cfg(e);
        hy = span(e[2], e[1], e[4], e[0]);
        wy = span(e[3], e[1], e[5], e[0]);
        res.filt = it.filt;
        res.row  = it.row;
        res.col  = it.col;
        res.bad  = (it.row >= hy) || (it.col >= wy);
        sum = 0;
        if (!res.bad) begin
          for (int k = 0; k < e[6]; k++)
            for (int i = 0; i < e[4]; i++)
              for (int j = 0; j < e[5]; j++) begin
                pr = it.row * e[0] + i - e[1];
                pc = it.col * e[0] + j - e[1];
                px = 0;
                if (pr >= 0 && pc >= 0 && pr < e[2] && pc < e[3])
                  px = img_mem[img_addr(k, pr, pc)];
                sum += longint'(px) * longint'(wgt_mem[wgt_addr(it.filt, k, i, j)]);
              end
          sum += longint'(bias_mem[it.filt]) * 256;
          if (sum > 64'sd549755813887) sum = 64'sd549755813887;
          if (sum < -64'sd549755813888) sum = -64'sd549755813888;
        end
        res.acc = sum[39:0];
        expected_results.push_back(res);
      end
    endcase
  endfunction

  // Driver: predict on each accepted item, then present the next one.
  always @(posedge clk) begin
    conv_item_t nxt;
    cycles <= cycles + 1;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        conv_predict(conv_item_t'({cmd_t'(s_tuser), s_tdata[15:0], s_tdata[19:16],
                                   s_tdata[22:20], s_tdata[28:23], s_tdata[34:29]}));
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.cmd;
          s_tdata  <= {5'b0, nxt.col, nxt.row, nxt.chan, nxt.filt, nxt.val};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each result with the oldest expectation.
  always @(posedge clk) begin
    conv_res_t want;
    conv_res_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[39:0], m_tdata[43:40], m_tdata[49:44], m_tdata[55:50], m_tuser};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: acc=%0d f=%0d r=%0d c=%0d bad=%0b",
                     $signed(got.acc), got.filt, got.row, got.col, got.bad);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp acc=%0d f=%0d r=%0d c=%0d bad=%0b",
                        " | got acc=%0d f=%0d r=%0d c=%0d bad=%0b"},
                       $signed(want.acc), want.filt, want.row, want.col, want.bad,
                       $signed(got.acc), got.filt, got.row, got.col, got.bad);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void push_item(cmd_t cmd, logic [15:0] val, int f, int ch, int r, int c);
    conv_item_t it;
    it.cmd = cmd; it.val = val; it.filt = 4'(f); it.chan = 3'(ch);
    it.row = 6'(r); it.col = 6'(c);
    pending.push_back(it);
  endfunction

  // Random Q8.8 value; extreme picks full-scale so products hit the rails.
  function automatic logic [15:0] pick_val(bit extreme);
    if (extreme) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return $urandom_range(15, 0) == 0 ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                      : 16'($urandom);
  endfunction

  // Load whatever the window of this compute still lacks, then queue it.
  function automatic void queue_compute(int f, int r, int c, bit extreme);
    int e[7];
    int pr, pc;
    eff_cfg(e);
    if (r < span(e[2], e[1], e[4], e[0]) && c < span(e[3], e[1], e[5], e[0])) begin
      for (int k = 0; k < e[6]; k++)
        for (int i = 0; i < e[4]; i++)
          for (int j = 0; j < e[5]; j++) begin
            pr = r * e[0] + i - e[1];
            pc = c * e[0] + j - e[1];
            if (pr >= 0 && pc >= 0 && pr < e[2] && pc < e[3] &&
                (extreme || !img_set[img_addr(k, pr, pc)])) begin
              img_set[img_addr(k, pr, pc)] = 1'b1;
              push_item(CMD_PIXEL, pick_val(extreme), 0, k, pr, pc);
            end
            if (extreme || !wgt_set[wgt_addr(f, k, i, j)]) begin
              wgt_set[wgt_addr(f, k, i, j)] = 1'b1;
              push_item(CMD_WEIGHT, pick_val(extreme), f, k, i, j);
            end
          end
      if (extreme || !bias_set[f]) begin
        bias_set[f] = 1'b1;
        push_item(CMD_BIAS, pick_val(extreme), f, 0, 0, 0);
      end
    end
    push_item(CMD_COMPUTE, 16'($urandom), f, $urandom_range(7), r, c);
  endfunction

  task automatic wait_idle();
    while (pending.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, int unsigned data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[7:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMG_H, REG_IMG_W: regs[idx] = data & 127;
      REG_CHAN:             regs[idx] = data & 15;
      default:              regs[idx] = data & 7;
    endcase
  endtask

  // One phase: a few noise loads and a batch of computes at random positions.
  task automatic run_phase(int n_compute);
    int e[7];
    int hy, wy, r, c;
    eff_cfg(e);
    hy = span(e[2], e[1], e[4], e[0]);
    wy = span(e[3], e[1], e[5], e[0]);
    for (int n = 0; n < n_compute; n++) begin
      case ($urandom_range(9))
        0: begin
          // stray loads: any pixel, weight taps also beyond the kernel store
          push_item(CMD_PIXEL, pick_val(0), $urandom_range(15), $urandom_range(7),
                    $urandom_range(63), $urandom_range(63));
          img_set[img_addr(pending[$].chan, pending[$].row, pending[$].col)] = 1'b1;
          push_item(CMD_WEIGHT, pick_val(0), $urandom_range(15), $urandom_range(7),
                    $urandom_range(63), $urandom_range(63));
          if (pending[$].row < MAX_KERNEL_SIDE && pending[$].col < MAX_KERNEL_SIDE)
            wgt_set[wgt_addr(pending[$].filt, pending[$].chan,
                             pending[$].row, pending[$].col)] = 1'b1;
        end
        1: begin
          r = $urandom_range(63);
          c = $urandom_range(63);
          queue_compute($urandom_range(15), r, c, 0);
        end
        default: begin
          r = (hy > 0) ? $urandom_range(hy - 1) : $urandom_range(63);
          c = (wy > 0) ? $urandom_range(wy - 1) : $urandom_range(63);
          queue_compute($urandom_range(15), r, c, 0);
        end
      endcase
      while (pending.size() > 64) @(posedge clk);
    end
    wait_idle();
  endtask

  // Register sets: minimum, maximum with channels above range, out of range
  // on both sides (clamps), kernel larger than image, then random small shapes.
  int unsigned fixed_sets[4][7] = '{
    '{1, 0, 1, 1, 1, 1, 1},
    '{4, 4, 64, 64, 5, 5, 15},
    '{7, 7, 0, 127, 0, 7, 0},
    '{1, 0, 3, 3, 5, 5, 2}
  };

  initial begin
    int unsigned vals[7];
    int n_phases;
    regs = '{1, 0, 64, 64, 3, 3, 1};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: default shape, corner positions, full-scale data.
    queue_compute(0, 0, 0, 1);
    queue_compute(15, 61, 61, 1);
    queue_compute(3, 0, 61, 1);
    queue_compute(7, 62, 0, 0);
    queue_compute(9, 63, 63, 0);
    queue_compute(15, 61, 61, 0);
    wait_idle();

    n_phases = 6;
    for (int p = 0; p < n_phases; p++) begin
      if (p < n_phases / 3) begin
        send_idle_pct = 22; recv_idle_pct = 81;
      end else if (p < 2 * n_phases / 3) begin
        send_idle_pct = 81; recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (p < 4) begin
        vals = fixed_sets[p];
      end else begin
        vals = '{$urandom_range(4, 1), $urandom_range(4), $urandom_range(12, 1),
                 $urandom_range(12, 1), $urandom_range(5, 1), $urandom_range(5, 1),
                 $urandom_range(3, 1)};
      end
      for (int i = 0; i < 7; i++) write_reg(reg_t'(i), vals[i]);
      // Max shape needs a full window of loads; one compute there.
      run_phase(p == 1 ? 1 : 6);
    end

    while (expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
